// ----- design/sme_pkg.sv -----
// shared constants, codes and controller/datapath command types
package sme_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int MEM_WORDS   = 512;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int IDX_W    = 9;
    localparam int STATUS_W = 3;

    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int COUNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int MEM_AW   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int STEP_W   = $clog2(WORD_W);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_STORE  = 3'd2,
        OP_ADD    = 3'd3,
        OP_DIV    = 3'd4,
        OP_OUTPUT = 3'd5,
        OP_END    = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_HALTED    = 3'd4,
        ST_ENDED     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        WR_LIT  = 2'd0,
        WR_LOAD = 2'd1,
        WR_SUM  = 2'd2,
        WR_QUOT = 2'd3
    } wr_sel_t;

    typedef struct packed {
        logic    latch_req;
        logic    stk_rd;
        logic    rd_second;
        logic    stk_wr;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    dmem_rd;
        logic    dmem_wr_pop;
        logic    clr_wr;
        logic    cap_b;
        logic    cap_pop;
        logic    div_start;
        logic    rsp_load;
        status_t rsp_status;
        logic    rsp_emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_empty;
        logic            cnt_lt2;
        logic            cnt_full;
        logic            b_zero;
        logic            div_done;
        logic            clr_last;
    } dp_stat_t;

endpackage

// ----- design/sme_req_if.sv -----
// instruction channel: valid/ready plus one pre-decoded instruction
interface sme_req_if;
    logic                              valid;
    logic                              ready;
    logic [sme_pkg::OP_W-1:0]          req_type;
    logic signed [sme_pkg::WORD_W-1:0] literal;
    logic [sme_pkg::IDX_W-1:0]         mem_index;

    modport source (output valid, output req_type, output literal, output mem_index,
                    input ready);
    modport sink (input valid, input req_type, input literal, input mem_index,
                  output ready);
endinterface

// ----- design/sme_rsp_if.sv -----
// result channel: valid/ready plus output flag, value and status
interface sme_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              out_valid;
    logic signed [sme_pkg::WORD_W-1:0] out_value;
    logic [sme_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output out_valid, output out_value, output status,
                    input ready);
    modport sink (input valid, input out_valid, input out_value, input status,
                  output ready);
endinterface

// ----- design/sme_ram.sv -----
// generic single-write, single-read ram with registered read data
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/sme_div.sv -----
// signed 32-bit divider, one restoring step per cycle, truncates toward zero
module sme_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sme_pkg::WORD_W-1:0]  dividend,
    input  logic [sme_pkg::WORD_W-1:0]  divisor,
    output logic                        done,
    output logic [sme_pkg::WORD_W-1:0]  quotient
);

    localparam int W = sme_pkg::WORD_W;

    logic                        busy_reg;
    logic                        done_reg;
    logic [sme_pkg::STEP_W-1:0]  step_reg;
    logic [W-1:0]                rem_reg;
    logic [W-1:0]                quo_reg;
    logic [W-1:0]                mag_d_reg;
    logic                        neg_reg;

    logic [W:0]   rem_shift;
    logic [W:0]   diff;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        diff      = rem_shift - {1'b0, mag_d_reg};
        if (!diff[W])
        begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + sme_pkg::STEP_W'(1);
            if (step_reg == sme_pkg::STEP_W'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg   <= dividend[W-1] ^ divisor[W-1];
            quo_reg   <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            mag_d_reg <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    // magnitude of most negative value stays 0x80000000, so min / -1 wraps
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// ----- design/sme_datapath.sv -----
// datapath: request latch, stack and data memories, stack count, divider, result register
module sme_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sme_pkg::OP_W-1:0]           req_type,
    input  logic signed [sme_pkg::WORD_W-1:0]  literal,
    input  logic [sme_pkg::IDX_W-1:0]          mem_index,
    input  sme_pkg::dp_cmd_t                   cmd,
    output sme_pkg::dp_stat_t                  stat,
    output logic                               out_valid,
    output logic signed [sme_pkg::WORD_W-1:0]  out_value,
    output logic [sme_pkg::STATUS_W-1:0]       status
);

    localparam int W  = sme_pkg::WORD_W;
    localparam int CW = sme_pkg::COUNT_W;
    localparam int SA = sme_pkg::STACK_AW;
    localparam int MA = sme_pkg::MEM_AW;

    logic [sme_pkg::OP_W-1:0]  op_reg;
    logic [W-1:0]              lit_reg;
    logic [sme_pkg::IDX_W-1:0] idx_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [W-1:0]              b_reg;
    logic [W-1:0]              pop_reg;
    logic [MA-1:0]             clr_addr_reg;
    logic                      out_valid_reg;
    logic [W-1:0]              out_value_reg;
    logic [sme_pkg::STATUS_W-1:0] status_reg;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          idx_ok;
    logic [MA-1:0] idx_addr;

    logic          stk_we;
    logic [SA-1:0] stk_waddr;
    logic [W-1:0]  stk_wdata;
    logic [SA-1:0] stk_raddr;
    logic [W-1:0]  stk_rdata;

    logic          dmem_we;
    logic [MA-1:0] dmem_waddr;
    logic [W-1:0]  dmem_wdata;
    logic [W-1:0]  dmem_rdata;

    logic          div_done;
    logic [W-1:0]  div_q;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign idx_ok   = 32'(idx_reg) < 32'(sme_pkg::MEM_WORDS);
    assign idx_addr = MA'(idx_reg);

    // stack memory
    assign stk_we    = cmd.stk_wr;
    assign stk_raddr = cmd.rd_second ? cnt_m2[SA-1:0] : cnt_m1[SA-1:0];

    always_comb
    begin
        stk_waddr = cnt_m2[SA-1:0];
        stk_wdata = lit_reg;
        case (cmd.wr_sel)
            sme_pkg::WR_LIT:
            begin
                stk_waddr = count_reg[SA-1:0];
                stk_wdata = lit_reg;
            end
            sme_pkg::WR_LOAD:
            begin
                stk_waddr = count_reg[SA-1:0];
                stk_wdata = idx_ok ? dmem_rdata : '0;
            end
            sme_pkg::WR_SUM:
            begin
                stk_wdata = stk_rdata + b_reg;
            end
            sme_pkg::WR_QUOT:
            begin
                stk_wdata = div_q;
            end
            default:
            begin
                stk_wdata = lit_reg;
            end
        endcase
    end

    sme_ram #(
        .WIDTH(W),
        .DEPTH(sme_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk  (clk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .re   (cmd.stk_rd),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    // data memory, swept to zero after reset
    assign dmem_we    = cmd.clr_wr | (cmd.dmem_wr_pop & idx_ok);
    assign dmem_waddr = cmd.clr_wr ? clr_addr_reg : idx_addr;
    assign dmem_wdata = cmd.clr_wr ? '0 : stk_rdata;

    sme_ram #(
        .WIDTH(W),
        .DEPTH(sme_pkg::MEM_WORDS)
    ) u_data_ram (
        .clk  (clk),
        .we   (dmem_we),
        .waddr(dmem_waddr),
        .wdata(dmem_wdata),
        .re   (cmd.dmem_rd),
        .raddr(idx_addr),
        .rdata(dmem_rdata)
    );

    sme_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(stk_rdata),
        .divisor (b_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = cnt_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + MA'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            op_reg  <= req_type;
            lit_reg <= literal;
            idx_reg <= mem_index;
        end
        if (cmd.cap_b)
        begin
            b_reg <= stk_rdata;
        end
        if (cmd.cap_pop)
        begin
            pop_reg <= stk_rdata;
        end
        if (cmd.rsp_load)
        begin
            out_valid_reg <= cmd.rsp_emit;
            out_value_reg <= cmd.rsp_emit ? pop_reg : '0;
            status_reg    <= cmd.rsp_status;
        end
    end

    assign stat.op        = op_reg;
    assign stat.cnt_empty = (count_reg == '0);
    assign stat.cnt_lt2   = (count_reg < CW'(2));
    assign stat.cnt_full  = (count_reg == CW'(sme_pkg::STACK_DEPTH));
    assign stat.b_zero    = (b_reg == '0);
    assign stat.div_done  = div_done;
    assign stat.clr_last  = (clr_addr_reg == MA'(sme_pkg::MEM_WORDS - 1));

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;

endmodule

// ----- design/sme_ctrl.sv -----
// controller: sequences each instruction, checks errors and keeps the halt flag
module sme_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  sme_pkg::dp_stat_t  stat,
    output sme_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_POP,
        S_RD_B,
        S_RD_A,
        S_DIV,
        S_RESP
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             halted_reg;
    logic             halted_next;
    sme_pkg::status_t code_reg;
    sme_pkg::status_t code_next;
    logic             emit_reg;
    logic             emit_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        halted_next    = halted_reg;
        code_next      = code_reg;
        emit_next      = emit_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        req_ready      = 1'b0;
        cmd.rsp_status = code_reg;
        cmd.rsp_emit   = emit_reg;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                code_next  = sme_pkg::ST_OK;
                emit_next  = 1'b0;
                state_next = S_RESP;
                if (halted_reg)
                begin
                    code_next = sme_pkg::ST_HALTED;
                end
                else
                begin
                    case (stat.op)
                        sme_pkg::OP_PUSH:
                        begin
                            if (stat.cnt_full)
                            begin
                                code_next   = sme_pkg::ST_OVERFLOW;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                cmd.stk_wr  = 1'b1;
                                cmd.wr_sel  = sme_pkg::WR_LIT;
                                cmd.cnt_inc = 1'b1;
                            end
                        end
                        sme_pkg::OP_LOAD:
                        begin
                            if (stat.cnt_full)
                            begin
                                code_next   = sme_pkg::ST_OVERFLOW;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                cmd.dmem_rd = 1'b1;
                                state_next  = S_LOAD;
                            end
                        end
                        sme_pkg::OP_STORE, sme_pkg::OP_OUTPUT:
                        begin
                            if (stat.cnt_empty)
                            begin
                                code_next   = sme_pkg::ST_UNDERFLOW;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                cmd.stk_rd = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        sme_pkg::OP_ADD, sme_pkg::OP_DIV:
                        begin
                            if (stat.cnt_lt2)
                            begin
                                code_next   = sme_pkg::ST_UNDERFLOW;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                cmd.stk_rd = 1'b1;
                                state_next = S_RD_B;
                            end
                        end
                        default:
                        begin
                            // end, and the unused code as well
                            code_next   = sme_pkg::ST_ENDED;
                            halted_next = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.stk_wr  = 1'b1;
                cmd.wr_sel  = sme_pkg::WR_LOAD;
                cmd.cnt_inc = 1'b1;
                state_next  = S_RESP;
            end
            S_POP:
            begin
                cmd.cnt_dec = 1'b1;
                if (stat.op == sme_pkg::OP_STORE)
                begin
                    cmd.dmem_wr_pop = 1'b1;
                end
                else
                begin
                    cmd.cap_pop = 1'b1;
                    emit_next   = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RD_B:
            begin
                // top word is b, fetch the one below it
                cmd.cap_b     = 1'b1;
                cmd.stk_rd    = 1'b1;
                cmd.rd_second = 1'b1;
                state_next    = S_RD_A;
            end
            S_RD_A:
            begin
                state_next = S_RESP;
                if (stat.op == sme_pkg::OP_DIV)
                begin
                    if (stat.b_zero)
                    begin
                        code_next   = sme_pkg::ST_DIVZERO;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    cmd.stk_wr  = 1'b1;
                    cmd.wr_sel  = sme_pkg::WR_SUM;
                    cmd.cnt_dec = 1'b1;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.stk_wr  = 1'b1;
                    cmd.wr_sel  = sme_pkg::WR_QUOT;
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.rsp_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            halted_reg    <= 1'b0;
            code_reg      <= sme_pkg::ST_OK;
            emit_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            halted_reg    <= halted_next;
            code_reg      <= code_next;
            emit_reg      <= emit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- design/stack_machine_executor.sv -----
// top level of the stack machine executor: controller plus datapath
//
//   channel  dir  payload                          handshake
//   req      in   req_type, literal, mem_index     req.valid / req.ready
//   rsp      out  out_valid, out_value, status     rsp.valid / rsp.ready
//
// one item at a time; each passes decode and response, and past decode
// a load also the load state, store and output the pop state, add and divide
// the read-b and read-a states, divide then the 32-step bit-per-cycle divider.
// after reset the data memory is swept to zero, one word a cycle, all MEM_WORDS
// words (512), with req.ready low.
// the result sits in an output register, so a new item is taken while it waits;
// the next result waits there until rsp.ready frees the register.
module stack_machine_executor (
    input logic        clk,
    input logic        rst_n,
    sme_req_if.sink    req,
    sme_rsp_if.source  rsp
);

    sme_pkg::dp_cmd_t  cmd;
    sme_pkg::dp_stat_t stat;

    sme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .rsp_valid(rsp.valid),
        .rsp_ready(rsp.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sme_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_type (req.req_type),
        .literal  (req.literal),
        .mem_index(req.mem_index),
        .cmd      (cmd),
        .stat     (stat),
        .out_valid(rsp.out_valid),
        .out_value(rsp.out_value),
        .status   (rsp.status)
    );

endmodule

// ----- tb/tb_stack_machine_executor.sv -----
// testbench for stack_machine_executor: instruction stream, result checker and watchdog
module tb_stack_machine_executor;

    localparam int WORD_W      = sme_pkg::WORD_W;
    localparam int OP_W        = sme_pkg::OP_W;
    localparam int IDX_W       = sme_pkg::IDX_W;
    localparam int STATUS_W    = sme_pkg::STATUS_W;
    localparam int STACK_DEPTH = sme_pkg::STACK_DEPTH;
    localparam int MEM_WORDS   = sme_pkg::MEM_WORDS;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam logic [WORD_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam int RANDOM_ITEMS = 1550;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE       = 60;

    typedef struct {
        logic              out_valid;
        logic [WORD_W-1:0] out_value;
        sme_pkg::status_t  status;
    } exec_result_t;

    class executor_checker;
        logic [WORD_W-1:0] words [STACK_DEPTH];
        logic [WORD_W-1:0] memory [MEM_WORDS];
        int                depth;
        bit                halted;
        int                failures;
        exec_result_t      expected_results [$];

        function new();
            foreach (memory[i])
                memory[i] = '0;
            depth    = 0;
            halted   = 1'b0;
            failures = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [WORD_W-1:0] top_word();
            return words[depth-1];
        endfunction

        // truncates toward zero; most negative / -1 wraps
        function logic [WORD_W-1:0] signed_quotient(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            logic [WORD_W-1:0] ma, mb, q;
            ma = a[WORD_W-1] ? -a : a;
            mb = b[WORD_W-1] ? -b : b;
            q  = ma / mb;
            return (a[WORD_W-1] != b[WORD_W-1]) ? -q : q;
        endfunction

        function exec_result_t run_instruction(logic [OP_W-1:0] op, logic [WORD_W-1:0] lit,
                                               logic [IDX_W-1:0] idx);
            exec_result_t r;
            logic [WORD_W-1:0] a, b;
            r.out_valid = 1'b0;
            r.out_value = '0;
            r.status    = sme_pkg::ST_OK;
            if (halted)
                r.status = sme_pkg::ST_HALTED;
            else
            begin
                case (op)
                    sme_pkg::OP_PUSH, sme_pkg::OP_LOAD:
                        if (depth >= STACK_DEPTH)
                            r.status = sme_pkg::ST_OVERFLOW;
                        else
                        begin
                            if (op == sme_pkg::OP_PUSH)
                                words[depth] = lit;
                            else
                                words[depth] = (idx < MEM_WORDS) ? memory[idx] : '0;
                            depth++;
                        end
                    sme_pkg::OP_STORE:
                        if (depth < 1)
                            r.status = sme_pkg::ST_UNDERFLOW;
                        else
                        begin
                            depth--;
                            if (idx < MEM_WORDS)
                                memory[idx] = words[depth];
                        end
                    sme_pkg::OP_ADD, sme_pkg::OP_DIV:
                        if (depth < 2)
                            r.status = sme_pkg::ST_UNDERFLOW;
                        else
                        begin
                            b = words[depth-1];
                            a = words[depth-2];
                            if (op == sme_pkg::OP_DIV && b == '0)
                                r.status = sme_pkg::ST_DIVZERO;
                            else
                            begin
                                depth--;
                                words[depth-1] = (op == sme_pkg::OP_ADD) ? a + b
                                                                         : signed_quotient(a, b);
                            end
                        end
                    sme_pkg::OP_OUTPUT:
                        if (depth < 1)
                            r.status = sme_pkg::ST_UNDERFLOW;
                        else
                        begin
                            depth--;
                            r.out_valid = 1'b1;
                            r.out_value = words[depth];
                        end
                    default:
                        r.status = sme_pkg::ST_ENDED;
                endcase
                if (r.status != sme_pkg::ST_OK)
                    halted = 1'b1;
            end
            return r;
        endfunction

        function void note_instruction(logic [OP_W-1:0] op, logic [WORD_W-1:0] lit,
                                       logic [IDX_W-1:0] idx);
            expected_results.push_back(run_instruction(op, lit, idx));
        endfunction

        function void check_result(logic ov, logic [WORD_W-1:0] val, logic [STATUS_W-1:0] st);
            exec_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result with no instruction outstanding");
                failures++;
                return;
            end
            e = expected_results.pop_front();
            if (ov !== e.out_valid)
            begin
                $error("out_valid: expected %0d, actual %0d", e.out_valid, ov);
                failures++;
            end
            if (val !== e.out_value)
            begin
                $error("out_value: expected %h, actual %h", e.out_value, val);
                failures++;
            end
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   gaps_on;
    int   quiet_cycles = 0;
    int   stall_left;
    int   stack_goal;

    sme_req_if req_if();
    sme_rsp_if rsp_if();

    executor_checker sb = new();

    stack_machine_executor u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
    endtask

    task automatic send(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] lit,
                        input logic [IDX_W-1:0] idx);
        if (gaps_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 15));
        @(negedge clk);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= op;
        req_if.literal   <= lit;
        req_if.mem_index <= idx;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_instruction(op, lit, idx);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return INT_MIN;
            3: return INT_MAX;
            4: return 32'd1;
            5, 6: return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 1) == 0)
            return IDX_W'($urandom_range(0, 15));
        return IDX_W'($urandom_range(0, MEM_WORDS - 1));
    endfunction

    function automatic logic [IDX_W-1:0] any_index();
        return IDX_W'($urandom);
    endfunction

    // one instruction that keeps the machine running
    task automatic send_legal();
        logic [OP_W-1:0] op;
        int r;
        r = $urandom_range(0, 99);
        if (sb.depth < stack_goal)
            op = (r < 45) ? sme_pkg::OP_PUSH : (r < 65) ? sme_pkg::OP_LOAD :
                 (r < 75) ? sme_pkg::OP_STORE : (r < 83) ? sme_pkg::OP_ADD :
                 (r < 91) ? sme_pkg::OP_DIV : sme_pkg::OP_OUTPUT;
        else
            op = (r < 15) ? sme_pkg::OP_PUSH : (r < 25) ? sme_pkg::OP_LOAD :
                 (r < 45) ? sme_pkg::OP_STORE : (r < 62) ? sme_pkg::OP_ADD :
                 (r < 80) ? sme_pkg::OP_DIV : sme_pkg::OP_OUTPUT;
        if ((op == sme_pkg::OP_STORE || op == sme_pkg::OP_OUTPUT) && sb.depth < 1)
            op = sme_pkg::OP_PUSH;
        if ((op == sme_pkg::OP_ADD || op == sme_pkg::OP_DIV) && sb.depth < 2)
            op = sme_pkg::OP_PUSH;
        if (op == sme_pkg::OP_DIV && sb.top_word() == '0)
            op = sme_pkg::OP_ADD;
        if ((op == sme_pkg::OP_PUSH || op == sme_pkg::OP_LOAD) && sb.depth >= STACK_DEPTH)
            op = sme_pkg::OP_OUTPUT;
        send(op, pick_word(), pick_index());
    endtask

    task automatic drain_to(input int level);
        while (sb.depth > level)
            send(sme_pkg::OP_OUTPUT, $urandom, any_index());
    endtask

    // receiver: stall bursts while gaps are enabled
    initial
    begin
        rsp_if.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.out_valid, rsp_if.out_value, rsp_if.status);
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int random_items;
        rst_n            = 1'b0;
        gaps_on          = 1'b0;
        stack_goal       = 8;
        req_if.valid     = 1'b0;
        req_if.req_type  = sme_pkg::OP_PUSH;
        req_if.literal   = '0;
        req_if.mem_index = '0;
        // filling the stack for an overflow costs up to a full stack of items
        kind         = $urandom_range(0, 6);
        random_items = (kind >= 5) ? RANDOM_ITEMS - STACK_DEPTH : RANDOM_ITEMS;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every operation but end, wrap cases, truncation, unwritten memory
        send(sme_pkg::OP_LOAD, $urandom, 9'd0);
        send(sme_pkg::OP_OUTPUT, $urandom, any_index());
        send(sme_pkg::OP_PUSH, INT_MIN, any_index());
        send(sme_pkg::OP_PUSH, '1, any_index());
        send(sme_pkg::OP_DIV, $urandom, any_index());
        send(sme_pkg::OP_OUTPUT, $urandom, any_index());
        send(sme_pkg::OP_PUSH, INT_MAX, any_index());
        send(sme_pkg::OP_PUSH, 32'd1, any_index());
        send(sme_pkg::OP_ADD, $urandom, any_index());
        send(sme_pkg::OP_STORE, $urandom, 9'd511);
        send(sme_pkg::OP_LOAD, $urandom, 9'd511);
        send(sme_pkg::OP_OUTPUT, $urandom, any_index());
        send(sme_pkg::OP_PUSH, -32'sd7, any_index());
        send(sme_pkg::OP_PUSH, 32'd2, any_index());
        send(sme_pkg::OP_DIV, $urandom, any_index());
        send(sme_pkg::OP_PUSH, 32'd7, any_index());
        send(sme_pkg::OP_PUSH, -32'sd2, any_index());
        send(sme_pkg::OP_DIV, $urandom, any_index());
        send(sme_pkg::OP_ADD, $urandom, any_index());
        send(sme_pkg::OP_STORE, $urandom, 9'd0);
        send(sme_pkg::OP_LOAD, $urandom, 9'd0);
        send(sme_pkg::OP_PUSH, 32'h5555_5555, any_index());
        send(sme_pkg::OP_ADD, $urandom, any_index());
        send(sme_pkg::OP_OUTPUT, $urandom, any_index());

        for (int n = 0; n < random_items; n++)
        begin
            if (n % 200 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if (n % 64 == 0)
                stack_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                         : $urandom_range(0, 24);
            if (n == random_items / 2)
            begin
                // let every outstanding result come back before going on
                hold_off(1);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (n == random_items - 150)
                gaps_on = 1'b0;
            send_legal();
        end

        // one way of stopping the machine, then items that must report halted
        case (kind)
            0: send(sme_pkg::OP_END, $urandom, any_index());
            1: send(OP_UNUSED, $urandom, any_index());
            2:
            begin
                drain_to(0);
                send(($urandom_range(0, 1) == 0) ? sme_pkg::OP_STORE : sme_pkg::OP_OUTPUT,
                     $urandom, any_index());
            end
            3:
            begin
                drain_to(1);
                if (sb.depth == 0)
                    send(sme_pkg::OP_PUSH, pick_word(), any_index());
                send(($urandom_range(0, 1) == 0) ? sme_pkg::OP_ADD : sme_pkg::OP_DIV,
                     $urandom, any_index());
            end
            4:
            begin
                send(sme_pkg::OP_PUSH, pick_word(), any_index());
                send(sme_pkg::OP_PUSH, '0, any_index());
                send(sme_pkg::OP_DIV, $urandom, any_index());
            end
            default:
            begin
                while (sb.depth < STACK_DEPTH)
                    send(($urandom_range(0, 1) == 0) ? sme_pkg::OP_PUSH : sme_pkg::OP_LOAD,
                         pick_word(), pick_index());
                send((kind == 5) ? sme_pkg::OP_PUSH : sme_pkg::OP_LOAD,
                     pick_word(), pick_index());
            end
        endcase
        for (int n = 0; n < 40; n++)
            send(OP_W'($urandom_range(0, 7)), $urandom, any_index());

        hold_off(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0)
            $error("%0d expected results never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
